// ----- rtl/esm_pkg.sv -----
// Shared types and constants for the forward-Euler state-space integrator.
package esm_pkg;

    localparam int MAX_STATES = 8;
    localparam int MAX_INPUTS = 8;
    localparam int FRAC_BITS  = 16;
    localparam int DT_FRAC    = 16;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 4;
    localparam int VAL_W      = 32;
    localparam int ACC_W      = 52;
    localparam int DT_W       = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [2:0] {
        CMD_LOAD_A    = 3'd0,
        CMD_LOAD_B    = 3'd1,
        CMD_LOAD_INIT = 3'd2,
        CMD_RESTORE   = 3'd3,
        CMD_INPUT     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        REG_DT       = 2'd0,
        REG_N_STATES = 2'd1,
        REG_N_INPUTS = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } state_t;

    // Operand travelling down the row of cells.
    typedef struct packed {
        logic                    valid;
        logic                    first;
        logic                    fin;
        logic                    is_b;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
    } op_t;

    // Load / restore broadcast to the cells.
    typedef struct packed {
        logic                    we_a;
        logic                    we_b;
        logic                    we_init;
        logic                    restore;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
    } ld_t;

    function automatic logic [CNT_W-1:0] act_cnt(input logic [CNT_W-1:0] n,
                                                 input logic [CNT_W-1:0] bound);
        logic [CNT_W-1:0] r;
        r = n;
        if (n == '0)
            r = CNT_W'(1);
        if (r > bound)
            r = bound;
        return r;
    endfunction

endpackage

// ----- rtl/euler_state_space_reference_model_unit.sv -----
// Top level: stream ports, sequencer, row of cells and result output register.
// An input element marked last starts a step: n_states+n_inputs operands are
// issued down the row of cells (one per cycle, each cell has its own
// multiplier), the sequencer waits until the last active cell is done, then
// n_states results leave one per cycle through the output register while
// m_tready allows. A step keeps s_tready low until the last result is taken;
// no input is taken meanwhile.
module euler_state_space_reference_model_unit
    import esm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [DT_W-1:0]        cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // command[2:0] row[5:3] col[8:6] value[40:9]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // state_index[2:0] state_value[34:3]
    output logic                   m_tlast
);

    logic [DT_W-1:0]  dt_reg;
    logic [CNT_W-1:0] nst_reg;
    logic [CNT_W-1:0] nin_reg;
    logic signed [VAL_W-1:0] ubuf_reg [MAX_INPUTS];
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] k_reg;
    logic [IDX_W-1:0] ecnt_reg;
    logic             edone_reg;
    op_t              op_reg;
    logic             m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    logic [CNT_W-1:0] ns, ni;
    logic [CNT_W:0]   total;
    logic [2:0]       cmd;
    logic [IDX_W-1:0] row, col;
    logic signed [VAL_W-1:0] val;
    logic             acc;
    logic             step_go;
    logic             issue_end;
    logic             wait_end;
    ld_t              ld;
    op_t              op_next;
    logic [IDX_W-1:0] bidx;

    op_t              chain [MAX_STATES+1];
    logic signed [VAL_W-1:0] xs [MAX_STATES];
    logic [MAX_STATES-1:0]   done;

    assign ns    = act_cnt(nst_reg, CNT_W'(MAX_STATES));
    assign ni    = act_cnt(nin_reg, CNT_W'(MAX_INPUTS));
    assign total = {1'b0, ns} + {1'b0, ni};
    assign cmd   = s_tdata[2:0];
    assign row   = s_tdata[5:3];
    assign col   = s_tdata[8:6];
    assign val   = s_tdata[40:9];
    assign s_tready = (state_reg == S_IDLE);
    assign acc   = s_tvalid && s_tready;

    always_comb
    begin
        ld = '0;
        ld.row = row;
        ld.col = col;
        ld.val = val;
        step_go = 1'b0;
        if (acc)
        begin
            case (cmd)
                CMD_LOAD_A:
                    ld.we_a = ({1'b0, row} < ns) && ({1'b0, col} < ns);
                CMD_LOAD_B:
                    ld.we_b = ({1'b0, row} < ns) && ({1'b0, col} < ni);
                CMD_LOAD_INIT:
                    ld.we_init = ({1'b0, row} < ns);
                CMD_RESTORE:
                    ld.restore = 1'b1;
                CMD_INPUT:
                    step_go = ({1'b0, col} < ni) && s_tlast;
                default:
                    ;
            endcase
        end
    end

    assign issue_end = ({1'b0, k_reg} == total - 1'b1);
    assign wait_end  = done[ns[IDX_W-1:0] - 1'b1];
    assign bidx      = IDX_W'(k_reg - ns);

    always_comb
    begin
        op_next = '0;
        if (state_reg == S_ISSUE)
        begin
            op_next.valid = 1'b1;
            op_next.first = (k_reg == '0);
            op_next.fin   = issue_end;
            if (k_reg < ns)
            begin
                op_next.is_b = 1'b0;
                op_next.idx  = k_reg[IDX_W-1:0];
                op_next.val  = xs[k_reg[IDX_W-1:0]];
            end
            else
            begin
                op_next.is_b = 1'b1;
                op_next.idx  = bidx;
                op_next.val  = ubuf_reg[bidx];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (step_go) state_next = S_ISSUE;
            S_ISSUE: if (issue_end) state_next = S_WAIT;
            S_WAIT:  if (wait_end) state_next = S_EMIT;
            S_EMIT:  if ((!m_tvalid_reg || m_tready) && edone_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dt_reg       <= DT_W'(655);
            nst_reg      <= CNT_W'(2);
            nin_reg      <= CNT_W'(1);
            for (int i = 0; i < MAX_INPUTS; i++)
                ubuf_reg[i] <= '0;
            k_reg        <= '0;
            ecnt_reg     <= '0;
            edone_reg    <= 1'b0;
            op_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DT:       dt_reg  <= cfg_data;
                    REG_N_STATES: nst_reg <= cfg_data[CNT_W-1:0];
                    REG_N_INPUTS: nin_reg <= cfg_data[CNT_W-1:0];
                    default:      ;
                endcase
            end
            if (acc && cmd == CMD_INPUT && {1'b0, col} < ni)
                ubuf_reg[col] <= val;

            if (state_reg == S_IDLE)
                k_reg <= '0;
            else if (state_reg == S_ISSUE)
                k_reg <= k_reg + 1'b1;

            if (state_reg == S_WAIT)
            begin
                ecnt_reg  <= '0;
                edone_reg <= 1'b0;
            end
            else if (state_reg == S_EMIT && (!m_tvalid_reg || m_tready))
            begin
                if (!edone_reg)
                begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= {5'b0, xs[ecnt_reg], ecnt_reg};
                    m_tlast_reg  <= ({1'b0, ecnt_reg} == ns - 1'b1);
                    edone_reg    <= ({1'b0, ecnt_reg} == ns - 1'b1);
                    ecnt_reg     <= ecnt_reg + 1'b1;
                end
                else
                    m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign chain[0] = op_reg;

    for (genvar g = 0; g < MAX_STATES; g++)
    begin : g_cell
        esm_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (CNT_W'(g) < ns),
            .sel    (ld.row == IDX_W'(g)),
            .ld     (ld),
            .dt     (dt_reg),
            .op_in  (chain[g]),
            .op_out (chain[g+1]),
            .x      (xs[g]),
            .done   (done[g])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while result pending");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("output run did not end after last state");

    a_issue_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ISSUE |-> !m_tvalid && !s_tready)
        else $error("ports active while operands issue");

endmodule

// ----- rtl/esm_cell.sv -----
// One row cell: holds A/B rows, initial and model state, runs its own MAC.
module esm_cell
    import esm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    sel,
    input  ld_t                     ld,
    input  logic [DT_W-1:0]         dt,
    input  op_t                     op_in,
    output op_t                     op_out,
    output logic signed [VAL_W-1:0] x,
    output logic                    done
);

    logic signed [VAL_W-1:0] a_reg [MAX_STATES];
    logic signed [VAL_W-1:0] b_reg [MAX_INPUTS];
    logic signed [VAL_W-1:0] init_reg;
    logic signed [VAL_W-1:0] x_reg;
    op_t                     pass_reg;

    logic signed [2*VAL_W-1:0] prod_reg;
    logic                      prod_v_reg;
    logic                      prod_first_reg;
    logic                      prod_fin_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      acc_fin_reg;
    logic signed [VAL_W+DT_W:0] mul_reg;
    logic                      mul_v_reg;
    logic                      done_reg;

    logic signed [VAL_W-1:0]   coeff;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [VAL_W-1:0]   deriv;
    logic signed [VAL_W+1:0]   sum;
    logic signed [VAL_W-1:0]   x_new;

    always_comb
    begin
        coeff = op_in.is_b ? b_reg[op_in.idx] : a_reg[op_in.idx];
        term  = ACC_W'(prod_reg >>> FRAC_BITS);
        acc_base = prod_first_reg ? '0 : acc_reg;
        if (acc_reg > ACC_W'(64'sh7FFF_FFFF))
            deriv = 32'sh7FFF_FFFF;
        else if (acc_reg < -ACC_W'(64'sh8000_0000))
            deriv = 32'sh8000_0000;
        else
            deriv = acc_reg[VAL_W-1:0];
        sum = (VAL_W+2)'(x_reg) + (VAL_W+2)'(mul_reg >>> DT_FRAC);
        if (sum > (VAL_W+2)'(64'sh7FFF_FFFF))
            x_new = 32'sh7FFF_FFFF;
        else if (sum < -(VAL_W+2)'(64'sh8000_0000))
            x_new = 32'sh8000_0000;
        else
            x_new = sum[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STATES; i++)
                a_reg[i] <= '0;
            for (int i = 0; i < MAX_INPUTS; i++)
                b_reg[i] <= '0;
            init_reg    <= '0;
            x_reg       <= '0;
            pass_reg    <= '0;
            prod_v_reg  <= 1'b0;
            acc_fin_reg <= 1'b0;
            mul_v_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (sel && ld.we_a)
                a_reg[ld.col] <= ld.val;
            if (sel && ld.we_b)
                b_reg[ld.col] <= ld.val;
            if (sel && ld.we_init)
                init_reg <= ld.val;

            pass_reg   <= op_in;
            prod_v_reg <= op_in.valid;
            acc_fin_reg <= prod_v_reg && prod_fin_reg;
            mul_v_reg  <= acc_fin_reg;
            done_reg   <= mul_v_reg;

            if (prod_v_reg)
                acc_reg <= acc_base + term;
            if (acc_fin_reg)
                mul_reg <= (VAL_W+DT_W+1)'(deriv) * $signed({1'b0, dt});

            if (ld.restore)
                x_reg <= init_reg;
            else if (mul_v_reg && en)
                x_reg <= x_new;
        end
    end

    // product data path, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg       <= (2*VAL_W)'(coeff) * (2*VAL_W)'(op_in.val);
        prod_first_reg <= op_in.first;
        prod_fin_reg   <= op_in.fin;
    end

    assign op_out = pass_reg;
    assign x      = x_reg;
    assign done   = done_reg;

endmodule
